// ----- src/ppd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and constants of the perceptual plane downscaler.
// ----------------------------------------------------------------------------
package ppd_pkg;

    localparam int MAX_IN_DIM     = 256;
    localparam int MAX_OUT_PIXELS = 16384;
    localparam int ADDR_W         = $clog2(MAX_OUT_PIXELS);
    localparam int SUM_W          = 30;
    localparam int SQ_W           = 46;
    localparam int RAM_W          = SUM_W + SQ_W;
    localparam int DIV_STEPS      = 52;
    localparam int SQRT_STEPS     = 26;

    localparam logic [12:0] EPS_Q32   = 13'd4295;
    localparam logic [25:0] R_DEFAULT = 26'h0020000;
    localparam logic [25:0] R_MAX     = 26'h3FFFFFF;

    localparam logic [1:0] CFG_IN_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_IN_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_SCALE_LOG2 = 2'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] sample;
    } ppd_in_t;

    typedef struct packed {
        logic signed [23:0] pixel_value;
        logic               last;
    } ppd_out_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LD_RD, ST_LD_WR, ST_FE_CRD, ST_FE_CACC, ST_FE_RD, ST_FE_ACC,
        ST_FE_MUL, ST_FE_CHK, ST_FE_DIV, ST_FE_SQRT, ST_FE_PROD, ST_FE_SUM, ST_FE_OUT
    } ppd_state_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_LD_RD, OP_LD_WR, OP_CRD, OP_CACC, OP_RD, OP_ACC,
        OP_MUL, OP_CHK, OP_DIV, OP_SQRT, OP_PROD, OP_SUM, OP_OUT
    } ppd_op_t;

    typedef struct packed {
        ppd_op_t     op;
        logic [1:0]  patch;
        logic [1:0]  blk;
        logic [5:0]  step;
    } ppd_cmd_t;

    typedef struct packed {
        logic empty;
        logic need_div;
        logic out_free;
    } ppd_sts_t;

endpackage

// ----- src/perceptual_plane_downscaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perceptual_plane_downscaler
// Top level: sequencer plus datapath of the perceptual plane downscaler.
// ----------------------------------------------------------------------------
// A load transaction reads, modifies and writes one block entry in the simple
// dual-port block store. A fetch transaction works through four patches in
// turn; each patch whose contrast ratio needs the shared divide/root unit
// also runs its 52 quotient steps and 26 root steps. Block store reads
// alternate with accumulation steps. A finished pixel waits in the output
// register while loads continue; the next fetch stalls only at its end if
// that pixel has not been taken. Blocks never loaded since reset read back
// undefined values.
module perceptual_plane_downscaler (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [8:0]        cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  ppd_pkg::ppd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ppd_pkg::ppd_out_t m_data
);

    ppd_pkg::ppd_cmd_t cmd;
    ppd_pkg::ppd_sts_t sts;

    ppd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_data.func),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ppd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- src/ppd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ppd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/ppd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_ctrl
// Sequencer for load and fetch transactions; drives datapath commands.
// ----------------------------------------------------------------------------
module ppd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_func,
    output logic              s_ready,
    input  ppd_pkg::ppd_sts_t sts,
    output ppd_pkg::ppd_cmd_t cmd
);

    ppd_pkg::ppd_state_t state_reg, state_next;
    logic [1:0] patch_reg, patch_next;
    logic [1:0] blk_reg, blk_next;
    logic [5:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppd_pkg::ST_IDLE;
            patch_reg <= '0;
            blk_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            patch_reg <= patch_next;
            blk_reg   <= blk_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        patch_next = patch_reg;
        blk_next   = blk_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        cmd.op     = ppd_pkg::OP_NOP;
        cmd.patch  = patch_reg;
        cmd.blk    = blk_reg;
        cmd.step   = step_reg;
        case (state_reg)
            ppd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == ppd_pkg::FUNC_LOAD) begin
                        cmd.op     = ppd_pkg::OP_LOAD;
                        state_next = ppd_pkg::ST_LD_RD;
                    end else if (!sts.empty) begin
                        state_next = ppd_pkg::ST_FE_CRD;
                    end
                end
            end
            ppd_pkg::ST_LD_RD: begin
                cmd.op     = ppd_pkg::OP_LD_RD;
                state_next = ppd_pkg::ST_LD_WR;
            end
            ppd_pkg::ST_LD_WR: begin
                cmd.op     = ppd_pkg::OP_LD_WR;
                state_next = ppd_pkg::ST_IDLE;
            end
            ppd_pkg::ST_FE_CRD: begin
                cmd.op     = ppd_pkg::OP_CRD;
                state_next = ppd_pkg::ST_FE_CACC;
            end
            ppd_pkg::ST_FE_CACC: begin
                cmd.op     = ppd_pkg::OP_CACC;
                patch_next = '0;
                blk_next   = '0;
                state_next = ppd_pkg::ST_FE_RD;
            end
            ppd_pkg::ST_FE_RD: begin
                cmd.op     = ppd_pkg::OP_RD;
                state_next = ppd_pkg::ST_FE_ACC;
            end
            ppd_pkg::ST_FE_ACC: begin
                cmd.op = ppd_pkg::OP_ACC;
                if (blk_reg == 2'd3) begin
                    state_next = ppd_pkg::ST_FE_MUL;
                end else begin
                    blk_next   = blk_reg + 2'd1;
                    state_next = ppd_pkg::ST_FE_RD;
                end
            end
            ppd_pkg::ST_FE_MUL: begin
                cmd.op     = ppd_pkg::OP_MUL;
                state_next = ppd_pkg::ST_FE_CHK;
            end
            ppd_pkg::ST_FE_CHK: begin
                cmd.op     = ppd_pkg::OP_CHK;
                step_next  = '0;
                state_next = ppd_pkg::ST_FE_DIV;
            end
            ppd_pkg::ST_FE_DIV: begin
                if (!sts.need_div) begin
                    state_next = ppd_pkg::ST_FE_PROD;
                end else begin
                    cmd.op = ppd_pkg::OP_DIV;
                    if (step_reg == 6'(ppd_pkg::DIV_STEPS - 1)) begin
                        step_next  = '0;
                        state_next = ppd_pkg::ST_FE_SQRT;
                    end else begin
                        step_next = step_reg + 6'd1;
                    end
                end
            end
            ppd_pkg::ST_FE_SQRT: begin
                cmd.op = ppd_pkg::OP_SQRT;
                if (step_reg == 6'(ppd_pkg::SQRT_STEPS - 1)) begin
                    state_next = ppd_pkg::ST_FE_PROD;
                end else begin
                    step_next = step_reg + 6'd1;
                end
            end
            ppd_pkg::ST_FE_PROD: begin
                cmd.op     = ppd_pkg::OP_PROD;
                state_next = ppd_pkg::ST_FE_SUM;
            end
            ppd_pkg::ST_FE_SUM: begin
                cmd.op   = ppd_pkg::OP_SUM;
                blk_next = '0;
                if (patch_reg == 2'd3) begin
                    state_next = ppd_pkg::ST_FE_OUT;
                end else begin
                    patch_next = patch_reg + 2'd1;
                    state_next = ppd_pkg::ST_FE_RD;
                end
            end
            ppd_pkg::ST_FE_OUT: begin
                if (sts.out_free) begin
                    cmd.op     = ppd_pkg::OP_OUT;
                    state_next = ppd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ppd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/ppd_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_dp
// Datapath: config, load counters, block store, patch statistics,
// shared divide/root unit, output register.
// ----------------------------------------------------------------------------
module ppd_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [8:0]        cfg_wdata,
    input  ppd_pkg::ppd_in_t  s_data,
    input  ppd_pkg::ppd_cmd_t cmd,
    output ppd_pkg::ppd_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output ppd_pkg::ppd_out_t m_data
);

    localparam int AW = ppd_pkg::ADDR_W;

    // config and position state
    logic [8:0] width_reg, height_reg;
    logic [2:0] scale_reg;
    logic [7:0] col_reg, row_reg;
    logic [6:0] fx_reg, fy_reg;

    // load latch
    logic [15:0]   smp_reg;
    logic [AW-1:0] ld_idx_reg;
    logic          ld_ok_reg, ld_first_reg;

    // patch statistics
    logic [29:0]        ls_reg;
    logic [31:0]        a_reg;
    logic [62:0]        b_reg;
    logic [47:0]        c_reg;
    logic [63:0]        aa_reg;
    logic [63:0]        den_reg, rem_reg;
    logic [51:0]        nl_reg, q_reg;
    logic [52:0]        res_reg;
    logic [25:0]        r_reg;
    logic               need_div_reg;
    logic signed [60:0] prod_reg;
    logic signed [63:0] t_reg;

    logic              m_valid_reg;
    ppd_pkg::ppd_out_t out_reg;

    // derived geometry
    logic [8:0] w_dim, h_dim;
    logic [2:0] k_val;
    logic [7:0] w2, h2, kmask;
    always_comb begin
        w_dim = (width_reg == 9'd0) ? 9'd1 :
                (width_reg > 9'(ppd_pkg::MAX_IN_DIM)) ? 9'(ppd_pkg::MAX_IN_DIM) : width_reg;
        h_dim = (height_reg == 9'd0) ? 9'd1 :
                (height_reg > 9'(ppd_pkg::MAX_IN_DIM)) ? 9'(ppd_pkg::MAX_IN_DIM) : height_reg;
        k_val = (scale_reg == 3'd0) ? 3'd1 : scale_reg;
        w2    = 8'(w_dim >> k_val);
        h2    = 8'(h_dim >> k_val);
        kmask = 8'((9'd1 << k_val) - 9'd1);
    end

    // load addressing
    logic [7:0]    cblk, rblk;
    logic          ld_ok, ld_first;
    logic [AW-1:0] ld_idx;
    logic [8:0]    col_inc, row_inc;
    always_comb begin
        cblk     = col_reg >> k_val;
        rblk     = row_reg >> k_val;
        ld_ok    = (cblk < w2) && (rblk < h2);
        ld_first = ((col_reg | row_reg) & kmask) == 8'd0;
        ld_idx   = AW'(16'(rblk * w2) + 16'(cblk));
        col_inc  = {1'b0, col_reg} + 9'd1;
        row_inc  = {1'b0, row_reg} + 9'd1;
    end

    // fetch addressing
    logic [7:0]    px, py, bx_raw, by_raw, bx, by;
    logic [AW-1:0] fe_idx, ctr_idx;
    always_comb begin
        if (cmd.patch[0]) begin
            px = (fx_reg == 7'd0) ? (w2 - 8'd1) : ({1'b0, fx_reg} - 8'd1);
        end else begin
            px = {1'b0, fx_reg};
        end
        if (cmd.patch[1]) begin
            py = (fy_reg == 7'd0) ? (h2 - 8'd1) : ({1'b0, fy_reg} - 8'd1);
        end else begin
            py = {1'b0, fy_reg};
        end
        bx_raw  = px + {7'd0, cmd.blk[0]};
        by_raw  = py + {7'd0, cmd.blk[1]};
        bx      = (bx_raw >= w2) ? (bx_raw - w2) : bx_raw;
        by      = (by_raw >= h2) ? (by_raw - h2) : by_raw;
        fe_idx  = AW'(16'(by * w2) + 16'(bx));
        ctr_idx = AW'(16'({1'b0, fy_reg} * w2) + 16'({1'b0, fx_reg}));
    end

    // block store
    logic                      ram_we;
    logic [AW-1:0]             ram_raddr;
    logic [ppd_pkg::RAM_W-1:0] ram_wdata, ram_rdata;
    logic [ppd_pkg::SUM_W-1:0] rd_sum, new_sum;
    logic [ppd_pkg::SQ_W-1:0]  rd_sq, new_sq;
    logic [31:0]               vv;

    always_comb begin
        rd_sum = ram_rdata[ppd_pkg::RAM_W-1:ppd_pkg::SQ_W];
        rd_sq  = ram_rdata[ppd_pkg::SQ_W-1:0];
        vv     = smp_reg * smp_reg;
        if (ld_first_reg) begin
            new_sum = ppd_pkg::SUM_W'(smp_reg);
            new_sq  = ppd_pkg::SQ_W'(vv);
        end else begin
            new_sum = rd_sum + ppd_pkg::SUM_W'(smp_reg);
            new_sq  = rd_sq + ppd_pkg::SQ_W'(vv);
        end
        ram_wdata = {new_sum, new_sq};
        ram_we    = (cmd.op == ppd_pkg::OP_LD_WR) && ld_ok_reg;
        case (cmd.op)
            ppd_pkg::OP_LD_RD: ram_raddr = ld_idx_reg;
            ppd_pkg::OP_CRD:   ram_raddr = ctr_idx;
            default:           ram_raddr = fe_idx;
        endcase
    end

    ppd_ram #(
        .WIDTH (ppd_pkg::RAM_W),
        .DEPTH (ppd_pkg::MAX_OUT_PIXELS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ld_idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // contrast check
    logic [65:0] ns, hi, nh, eps;
    logic [4:0]  hi_sh;
    logic [5:0]  eps_sh;
    always_comb begin
        hi_sh  = 5'd2 + {1'b0, k_val, 1'b0};
        eps_sh = 6'd4 + {1'b0, k_val, 2'b00};
        ns     = {1'b0, b_reg, 2'b00} - {2'b00, aa_reg};
        hi     = {18'd0, c_reg} << hi_sh;
        nh     = (hi >= {2'b00, aa_reg}) ? (hi - {2'b00, aa_reg}) : 66'd0;
        eps    = {53'd0, ppd_pkg::EPS_Q32} << eps_sh;
    end

    // divide and root steps
    logic [64:0] div_rs;
    logic [52:0] sq_bit, sq_trial, sq_v;
    logic [5:0]  sq_sh;
    always_comb begin
        div_rs   = {rem_reg, nl_reg[51]};
        sq_sh    = 6'd50 - {cmd.step[4:0], 1'b0};
        sq_bit   = 53'd1 << sq_sh;
        sq_trial = res_reg + sq_bit;
        sq_v     = {1'b0, q_reg};
    end

    // product and final rounding
    logic [25:0]        r_use;
    logic signed [33:0] diff;
    logic signed [65:0] nv, rnd, val;
    logic [5:0]         out_sh;
    logic signed [23:0] sat;
    logic               out_last;
    always_comb begin
        r_use  = need_div_reg ? res_reg[25:0] : r_reg;
        diff   = $signed({2'b00, ls_reg, 2'b00}) - $signed({2'b00, a_reg});
        out_sh = 6'd21 + {2'b00, k_val, 1'b0};
        nv     = $signed({{2{t_reg[63]}}, t_reg}) + $signed({16'd0, ls_reg, 20'd0});
        rnd    = nv + $signed(66'd1 << (out_sh - 6'd1));
        val    = rnd >>> out_sh;
        if (!val[65] && (|val[64:23])) begin
            sat = 24'sh7FFFFF;
        end else if (val[65] && !(&val[64:23])) begin
            sat = -24'sh800000;
        end else begin
            sat = val[23:0];
        end
        out_last = ({1'b0, fx_reg} == w2 - 8'd1) && ({1'b0, fy_reg} == h2 - 8'd1);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= 9'd16;
            height_reg  <= 9'd16;
            scale_reg   <= 3'd1;
            col_reg     <= '0;
            row_reg     <= '0;
            fx_reg      <= '0;
            fy_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == ppd_pkg::OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    ppd_pkg::CFG_IN_WIDTH:   width_reg  <= cfg_wdata;
                    ppd_pkg::CFG_IN_HEIGHT:  height_reg <= cfg_wdata;
                    ppd_pkg::CFG_SCALE_LOG2: scale_reg  <= cfg_wdata[2:0];
                    default: ;
                endcase
                if (cfg_index == ppd_pkg::CFG_IN_WIDTH || cfg_index == ppd_pkg::CFG_IN_HEIGHT
                    || cfg_index == ppd_pkg::CFG_SCALE_LOG2) begin
                    col_reg <= '0;
                    row_reg <= '0;
                    fx_reg  <= '0;
                    fy_reg  <= '0;
                end
            end else if (cmd.op == ppd_pkg::OP_LOAD) begin
                if (col_inc >= w_dim) begin
                    col_reg <= '0;
                    row_reg <= (row_inc >= h_dim) ? 8'd0 : row_inc[7:0];
                end else begin
                    col_reg <= col_inc[7:0];
                end
            end else if (cmd.op == ppd_pkg::OP_OUT) begin
                if ({1'b0, fx_reg} == w2 - 8'd1) begin
                    fx_reg <= '0;
                    fy_reg <= ({1'b0, fy_reg} == h2 - 8'd1) ? 7'd0 : fy_reg + 7'd1;
                end else begin
                    fx_reg <= fx_reg + 7'd1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        case (cmd.op)
            ppd_pkg::OP_LOAD: begin
                smp_reg      <= s_data.sample;
                ld_idx_reg   <= ld_idx;
                ld_ok_reg    <= ld_ok;
                ld_first_reg <= ld_first;
            end
            ppd_pkg::OP_CACC: begin
                ls_reg <= rd_sum;
                t_reg  <= '0;
                a_reg  <= '0;
                b_reg  <= '0;
                c_reg  <= '0;
            end
            ppd_pkg::OP_ACC: begin
                a_reg <= a_reg + 32'(rd_sum);
                b_reg <= b_reg + 63'(rd_sum * rd_sum);
                c_reg <= c_reg + 48'(rd_sq);
            end
            ppd_pkg::OP_MUL: begin
                aa_reg <= a_reg * a_reg;
            end
            ppd_pkg::OP_CHK: begin
                den_reg <= ns[63:0];
                rem_reg <= 64'(nh >> 20);
                nl_reg  <= {nh[19:0], 32'd0};
                q_reg   <= '0;
                res_reg <= '0;
                if (ns < eps) begin
                    r_reg        <= ppd_pkg::R_DEFAULT;
                    need_div_reg <= 1'b0;
                end else if ((nh >> 20) >= ns) begin
                    r_reg        <= ppd_pkg::R_MAX;
                    need_div_reg <= 1'b0;
                end else begin
                    need_div_reg <= 1'b1;
                end
            end
            ppd_pkg::OP_DIV: begin
                nl_reg <= {nl_reg[50:0], 1'b0};
                if (div_rs >= {1'b0, den_reg}) begin
                    rem_reg <= 64'(div_rs - {1'b0, den_reg});
                    q_reg   <= {q_reg[50:0], 1'b1};
                end else begin
                    rem_reg <= div_rs[63:0];
                    q_reg   <= {q_reg[50:0], 1'b0};
                end
            end
            ppd_pkg::OP_SQRT: begin
                if (sq_v >= sq_trial) begin
                    q_reg   <= 52'(sq_v - sq_trial);
                    res_reg <= (res_reg >> 1) + sq_bit;
                end else begin
                    res_reg <= res_reg >> 1;
                end
            end
            ppd_pkg::OP_PROD: begin
                prod_reg <= $signed({1'b0, r_use}) * diff;
            end
            ppd_pkg::OP_SUM: begin
                t_reg <= t_reg + $signed({16'd0, a_reg, 16'd0})
                       + $signed({{3{prod_reg[60]}}, prod_reg});
                a_reg <= '0;
                b_reg <= '0;
                c_reg <= '0;
            end
            ppd_pkg::OP_OUT: begin
                out_reg.pixel_value <= sat;
                out_reg.last        <= out_last;
            end
            default: ;
        endcase
    end

    assign sts.empty    = (w2 == 8'd0) || (h2 == 8'd0);
    assign sts.need_div = need_div_reg;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = out_reg;

endmodule

// ----- src/ppd_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_chk
// Port-level checks of the downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module ppd_chk (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input ppd_pkg::ppd_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input ppd_pkg::ppd_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func == ppd_pkg::FUNC_LOAD |=> !s_ready)
        else $error("load transaction did not occupy the store");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func == ppd_pkg::FUNC_LOAD && !m_valid |=> !m_valid)
        else $error("load transaction produced a result");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

endmodule

bind perceptual_plane_downscaler ppd_chk u_ppd_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
